// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the token classifier modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CSS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define CSS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/css_tc_pkg.sv =====
// Shared types and constants for the CSS token classifier.
package css_tc_pkg;

   localparam int LENGTH_BITS_DEFAULT = 16;
   localparam int TOKEN_LENGTH_W      = 16;
   localparam int QUEUE_DEPTH         = 4;

   typedef enum logic [3:0] {
      KIND_UNKNOWN  = 4'd0,
      KIND_SPACE    = 4'd1,
      KIND_IDENT    = 4'd2,
      KIND_FUNCTION = 4'd3,
      KIND_HASH     = 4'd4,
      KIND_ATKW     = 4'd5,
      KIND_NSPREFIX = 4'd6,
      KIND_STAR     = 4'd7,
      KIND_COLON    = 4'd8,
      KIND_CLASS    = 4'd9,
      KIND_COMMENT  = 4'd10
   } kind_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      kind_type                    token_kind;
      logic [TOKEN_LENGTH_W-1:0]   token_length;
      logic                        last_of_run;
   } rsp_type;

   // Everything one input byte produces: one token, or two when the byte
   // both closes a token and forms an immediate one.
   typedef struct packed {
      logic    two;
      rsp_type first;
      rsp_type second;
   } rec_type;

endpackage

// ===== rtl/css_token_classifier.sv =====
// Top level of the CSS token classifier: scanner, record queue, result stage.
//
//   channel | ports                          | transfer when
//   --------+--------------------------------+---------------------
//   req     | req_push, req_full, req_data   | req_push && !req_full
//   rsp     | rsp_pop, rsp_empty, rsp_data   | rsp_pop && !rsp_empty
//
// One text byte is taken every cycle that req_full is low; the scanner mode
// and length counter update in that same cycle and write at most one record
// to the queue. Results leave at one token per cycle while popped; a byte
// that closes a token and forms a colon or unknown token gives two results.
// Four records queue between scanner and result register; req_full follows
// the queue only. Synchronous reset returns to idle and empties both sides.
module css_token_classifier #(
   parameter int LENGTH_BITS = css_tc_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  css_tc_pkg::req_type req_data,
   output logic                req_full,
   output logic                rsp_empty,
   output css_tc_pkg::rsp_type rsp_data,
   input  logic                rsp_pop
);

   logic                q_push, q_full, q_pop, q_empty;
   css_tc_pkg::rec_type q_wdata, q_rdata;

   css_tc_front #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_push   (q_push),
      .q_data   (q_wdata),
      .q_full   (q_full)
   );

   css_tc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   css_tc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_rdata),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

endmodule

// ===== rtl/css_tc_front.sv =====
// Scanner front end: tracks the token mode and emits at most one record per byte.
`include "assert_macros.svh"

module css_tc_front #(
   parameter int LENGTH_BITS = css_tc_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  css_tc_pkg::req_type req_data,
   output logic                req_full,
   output logic                q_push,
   output css_tc_pkg::rec_type q_data,
   input  logic                q_full
);

   localparam int CNT_W = (LENGTH_BITS > css_tc_pkg::TOKEN_LENGTH_W) ?
                          css_tc_pkg::TOKEN_LENGTH_W : LENGTH_BITS;

   localparam logic [7:0] CH_PIPE   = 8'h7C;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_USCORE = 8'h5F;

   typedef enum logic [10:0] {
      M_IDLE    = 11'b000_0000_0001,
      M_SPACE   = 11'b000_0000_0010,
      M_IDENT   = 11'b000_0000_0100,
      M_STAR    = 11'b000_0000_1000,
      M_AT      = 11'b000_0001_0000,
      M_ATKW    = 11'b000_0010_0000,
      M_DOT     = 11'b000_0100_0000,
      M_CLASS   = 11'b000_1000_0000,
      M_HASH    = 11'b001_0000_0000,
      M_SLASH   = 11'b010_0000_0000,
      M_COMMENT = 11'b100_0000_0000
   } mode_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0C || c == 8'h0D;
   endfunction

   function automatic logic is_name_start(input logic [7:0] c);
      return c == CH_DASH || c == CH_USCORE || is_alpha(c);
   endfunction

   function automatic logic is_name_char(input logic [7:0] c);
      return c == CH_USCORE || is_alpha(c) || is_digit(c);
   endfunction

   mode_type             mode_ff, mode_in;
   logic [CNT_W-1:0]     len_ff, len_in;
   logic                 star_ff, star_in;
   logic                 dash_ff, dash_in;

   logic                 accept;
   logic [7:0]           b;
   logic [CNT_W-1:0]     len_inc;

   mode_type             st_mode;
   logic                 st_dash;
   logic                 st_imm;
   css_tc_pkg::kind_type st_imm_kind;

   logic                 close_v;
   css_tc_pkg::kind_type close_kind;
   logic [CNT_W-1:0]     close_len;
   logic                 imm_v;
   logic                 do_start;
   css_tc_pkg::kind_type name_k;

   assign accept   = req_push && !req_full;
   assign req_full = q_full;
   assign b        = req_data.text_byte;
   assign len_inc  = (&len_ff) ? len_ff : len_ff + 1'b1;

   // What a byte opens when it starts a new token.
   always_comb begin
      st_mode     = M_IDLE;
      st_dash     = 1'b0;
      st_imm      = 1'b0;
      st_imm_kind = css_tc_pkg::KIND_UNKNOWN;
      if (is_ws(b)) begin
         st_mode = M_SPACE;
      end else if (is_name_start(b)) begin
         st_mode = M_IDENT;
         st_dash = (b == CH_DASH);
      end else if (b == CH_STAR) begin
         st_mode = M_STAR;
      end else if (b == CH_COLON) begin
         st_imm      = 1'b1;
         st_imm_kind = css_tc_pkg::KIND_COLON;
      end else if (b == CH_AT) begin
         st_mode = M_AT;
      end else if (b == CH_DOT) begin
         st_mode = M_DOT;
      end else if (b == CH_HASH) begin
         st_mode = M_HASH;
      end else if (b == CH_SLASH) begin
         st_mode = M_SLASH;
      end else begin
         st_imm = 1'b1;
      end
   end

   always_comb begin
      mode_in    = mode_ff;
      len_in     = len_ff;
      star_in    = star_ff;
      dash_in    = dash_ff;
      close_v    = 1'b0;
      close_kind = css_tc_pkg::KIND_UNKNOWN;
      close_len  = CNT_W'(1);
      imm_v      = 1'b0;
      do_start   = 1'b0;
      name_k     = (mode_ff == M_IDENT) ? css_tc_pkg::KIND_IDENT :
                   (mode_ff == M_ATKW)  ? css_tc_pkg::KIND_ATKW : css_tc_pkg::KIND_CLASS;

      if (accept && req_data.end_of_text) begin
         close_len = len_ff;
         unique case (mode_ff) inside
            M_IDLE: begin
            end
            M_SPACE: begin
               close_v    = 1'b1;
               close_kind = css_tc_pkg::KIND_SPACE;
            end
            M_IDENT, M_ATKW, M_CLASS: begin
               close_v    = 1'b1;
               close_kind = name_k;
            end
            M_STAR: begin
               close_v    = 1'b1;
               close_kind = css_tc_pkg::KIND_STAR;
               close_len  = CNT_W'(1);
            end
            M_HASH: begin
               close_v    = 1'b1;
               close_kind = (len_ff > CNT_W'(1)) ? css_tc_pkg::KIND_HASH :
                                                   css_tc_pkg::KIND_UNKNOWN;
            end
            M_AT, M_DOT, M_SLASH: begin
               close_v   = 1'b1;
               close_len = CNT_W'(1);
            end
            M_COMMENT: begin
               // unterminated comment flushes as unknown
               close_v = 1'b1;
            end
            default: begin
            end
         endcase
         mode_in = M_IDLE;
         len_in  = '0;
         star_in = 1'b0;
         dash_in = 1'b0;
      end else if (accept) begin
         unique case (mode_ff) inside
            M_IDLE: begin
               do_start = 1'b1;
            end
            M_SPACE: begin
               if (is_ws(b)) begin
                  len_in = len_inc;
               end else begin
                  close_v    = 1'b1;
                  close_kind = css_tc_pkg::KIND_SPACE;
                  close_len  = len_ff;
                  do_start   = 1'b1;
               end
            end
            M_IDENT, M_ATKW, M_CLASS: begin
               if ((dash_ff && b == CH_DASH) || is_name_char(b)) begin
                  dash_in = 1'b0;
                  len_in  = len_inc;
               end else if (mode_ff == M_IDENT && (b == CH_LPAREN || b == CH_PIPE)) begin
                  close_v    = 1'b1;
                  close_kind = (b == CH_LPAREN) ? css_tc_pkg::KIND_FUNCTION :
                                                  css_tc_pkg::KIND_NSPREFIX;
                  close_len  = len_inc;
                  mode_in    = M_IDLE;
                  len_in     = '0;
                  star_in    = 1'b0;
                  dash_in    = 1'b0;
               end else begin
                  close_v    = 1'b1;
                  close_kind = name_k;
                  close_len  = len_ff;
                  do_start   = 1'b1;
               end
            end
            M_STAR: begin
               close_v = 1'b1;
               if (b == CH_PIPE) begin
                  close_kind = css_tc_pkg::KIND_NSPREFIX;
                  close_len  = CNT_W'(2);
                  mode_in    = M_IDLE;
                  len_in     = '0;
               end else begin
                  close_kind = css_tc_pkg::KIND_STAR;
                  do_start   = 1'b1;
               end
            end
            M_AT, M_DOT: begin
               if (is_name_start(b)) begin
                  mode_in = (mode_ff == M_AT) ? M_ATKW : M_CLASS;
                  len_in  = CNT_W'(2);
                  dash_in = (b == CH_DASH);
               end else begin
                  close_v  = 1'b1;
                  do_start = 1'b1;
               end
            end
            M_HASH: begin
               if (b == CH_DASH || is_name_char(b)) begin
                  len_in = len_inc;
               end else begin
                  close_v    = 1'b1;
                  close_kind = (len_ff > CNT_W'(1)) ? css_tc_pkg::KIND_HASH :
                                                      css_tc_pkg::KIND_UNKNOWN;
                  close_len  = len_ff;
                  do_start   = 1'b1;
               end
            end
            M_SLASH: begin
               if (b == CH_STAR) begin
                  mode_in = M_COMMENT;
                  len_in  = CNT_W'(2);
                  star_in = 1'b0;
               end else begin
                  close_v  = 1'b1;
                  do_start = 1'b1;
               end
            end
            M_COMMENT: begin
               if (star_ff && b == CH_SLASH) begin
                  close_v    = 1'b1;
                  close_kind = css_tc_pkg::KIND_COMMENT;
                  close_len  = len_inc;
                  mode_in    = M_IDLE;
                  len_in     = '0;
                  star_in    = 1'b0;
               end else begin
                  len_in  = len_inc;
                  star_in = (b == CH_STAR);
               end
            end
            default: begin
               mode_in = M_IDLE;
            end
         endcase

         if (do_start) begin
            mode_in = st_mode;
            len_in  = CNT_W'(1);
            star_in = 1'b0;
            dash_in = st_dash;
            imm_v   = st_imm;
         end
      end
   end

   always_comb begin
      q_push                     = close_v || imm_v;
      q_data.two                 = close_v && imm_v;
      q_data.first.token_kind    = close_v ? close_kind : st_imm_kind;
      q_data.first.token_length  = close_v ? css_tc_pkg::TOKEN_LENGTH_W'(close_len) :
                                             css_tc_pkg::TOKEN_LENGTH_W'(1);
      q_data.first.last_of_run   = !(close_v && imm_v);
      q_data.second.token_kind   = st_imm_kind;
      q_data.second.token_length = css_tc_pkg::TOKEN_LENGTH_W'(1);
      q_data.second.last_of_run  = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         len_ff  <= '0;
         star_ff <= 1'b0;
         dash_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         len_ff  <= len_in;
         star_ff <= star_in;
         dash_ff <= dash_in;
      end
   end

   `CSS_ASSERT_NEXT(a_flush_idle, accept && req_data.end_of_text, mode_ff == M_IDLE, "flush left a token open")
   `CSS_ASSERT(a_no_push_full, !(q_push && q_full), "record written into full queue")

endmodule

// ===== rtl/css_tc_queue.sv =====
// Short record queue between the scanner and the result stage.
`include "assert_macros.svh"

module css_tc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  css_tc_pkg::rec_type push_data,
   output logic                full,
   input  logic                pop,
   output css_tc_pkg::rec_type pop_data,
   output logic                empty
);

   localparam int DEPTH = css_tc_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   css_tc_pkg::rec_type mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `CSS_ASSERT(a_count_range, count_ff <= CNT_W'(DEPTH), "queue count beyond depth")
   `CSS_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_ff == $past(count_ff) + 1'b1, "count missed a write")

endmodule

// ===== rtl/css_tc_back.sv =====
// Result stage: unpacks records into single tokens behind an output register.
`include "assert_macros.svh"

module css_tc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  css_tc_pkg::rec_type q_data,
   output logic                q_pop,
   output logic                rsp_empty,
   output css_tc_pkg::rsp_type rsp_data,
   input  logic                rsp_pop
);

   css_tc_pkg::rec_type hold_ff, hold_in;
   logic                valid_ff, valid_in;
   logic                second_ff, second_in;
   logic                take, done, load;

   assign rsp_empty = !valid_ff;
   assign rsp_data  = second_ff ? hold_ff.second : hold_ff.first;
   assign take      = rsp_pop && valid_ff;
   assign done      = take && (second_ff || !hold_ff.two);
   assign load      = (!valid_ff || done) && !q_empty;
   assign q_pop     = load;

   always_comb begin
      hold_in   = hold_ff;
      valid_in  = valid_ff;
      second_in = second_ff;
      if (load) begin
         hold_in   = q_data;
         valid_in  = 1'b1;
         second_in = 1'b0;
      end else if (done) begin
         valid_in  = 1'b0;
         second_in = 1'b0;
      end else if (take) begin
         // first of a pair went out, show the immediate token next
         second_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   `CSS_ASSERT(a_second_pair, !second_ff || (valid_ff && hold_ff.two), "second token without a pair")
   `CSS_ASSERT_NEXT(a_pair_advance, take && !second_ff && hold_ff.two, valid_ff && second_ff, "pair lost its second token")

endmodule

// ===== test/tb_css_token_classifier.sv =====
// Testbench for css_token_classifier: random CSS text against a scoreboard-based token predictor.
`timescale 1ns / 1ps

module tb_css_token_classifier;

   localparam int LEN_MAX = (css_tc_pkg::LENGTH_BITS_DEFAULT >= 16) ? 65535 :
                            (1 << css_tc_pkg::LENGTH_BITS_DEFAULT) - 1;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int BUSY_BYTES = 450;
   localparam int CALM_BYTES = 150;
   localparam int LONG_HOLD = 300;
   localparam int DRAIN_CYCLES = 20;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_FF = 8'h0C;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_DASH = 8'h2D;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_PIPE = 8'h7C;
   localparam logic [7:0] CH_AT = 8'h40;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   css_tc_pkg::req_type req_data = '0;
   logic req_full;
   logic rsp_empty;
   css_tc_pkg::rsp_type rsp_data;
   logic rsp_pop = 1'b0;

   bit sender_idles = 1'b0;
   bit receiver_idles = 1'b0;
   bit hold_request = 1'b0;
   int unsigned cycle_count = 0;
   int unsigned sent_bytes = 0;

   class token_scoreboard;
      typedef enum int {
         SCAN_IDLE, SCAN_SPACE, SCAN_IDENT, SCAN_STAR, SCAN_AT, SCAN_ATKW,
         SCAN_DOT, SCAN_CLASS, SCAN_HASH, SCAN_SLASH, SCAN_COMMENT
      } scan_mode_type;

      scan_mode_type mode;
      int unsigned run_len;
      bit cr_seen;
      bit star_seen;
      int unsigned dash_count;
      css_tc_pkg::rsp_type step_q[$];
      css_tc_pkg::rsp_type expected_q[$];
      int unsigned failures;

      function new();
         clear_token();
         cr_seen = 1'b0;
         failures = 0;
      endfunction

      function void clear_token();
         mode = SCAN_IDLE;
         run_len = 0;
         star_seen = 1'b0;
         dash_count = 0;
      endfunction

      function int unsigned bump(int unsigned v);
         return (v < LEN_MAX) ? v + 1 : LEN_MAX;
      endfunction

      function bit is_blank(logic [7:0] b);
         return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_FF || b == CH_CR;
      endfunction

      function bit is_letter(logic [7:0] b);
         return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
      endfunction

      function bit is_digit(logic [7:0] b);
         return b >= 8'h30 && b <= 8'h39;
      endfunction

      function bit is_name_start(logic [7:0] b);
         return b == CH_DASH || b == CH_UNDERSCORE || is_letter(b);
      endfunction

      function bit is_name_char(logic [7:0] b);
         return b == CH_UNDERSCORE || is_letter(b) || is_digit(b);
      endfunction

      function css_tc_pkg::kind_type name_kind();
         case (mode)
            SCAN_IDENT: return css_tc_pkg::KIND_IDENT;
            SCAN_ATKW: return css_tc_pkg::KIND_ATKW;
            default: return css_tc_pkg::KIND_CLASS;
         endcase
      endfunction

      function void emit(css_tc_pkg::kind_type k, int unsigned len);
         css_tc_pkg::rsp_type t;
         t.token_kind = k;
         t.token_length = 16'((len > LEN_MAX) ? LEN_MAX : len);
         t.last_of_run = 1'b0;
         step_q.push_back(t);
      endfunction

      // first byte of a new token; colon and unknown bytes are reported at once
      function void open_token(logic [7:0] b);
         clear_token();
         if (is_blank(b)) begin
            mode = SCAN_SPACE;
            run_len = 1;
            cr_seen = (b == CH_CR);
         end else if (is_name_start(b)) begin
            mode = SCAN_IDENT;
            run_len = 1;
            dash_count = (b == CH_DASH) ? 1 : 0;
         end else if (b == CH_STAR) begin
            mode = SCAN_STAR;
            run_len = 1;
         end else if (b == CH_COLON) begin
            emit(css_tc_pkg::KIND_COLON, 1);
         end else if (b == CH_AT) begin
            mode = SCAN_AT;
            run_len = 1;
         end else if (b == CH_DOT) begin
            mode = SCAN_DOT;
            run_len = 1;
         end else if (b == CH_HASH) begin
            mode = SCAN_HASH;
            run_len = 1;
         end else if (b == CH_SLASH) begin
            mode = SCAN_SLASH;
            run_len = 1;
         end else begin
            emit(css_tc_pkg::KIND_UNKNOWN, 1);
         end
      endfunction

      function void note_byte(css_tc_pkg::req_type r);
         logic [7:0] b;
         css_tc_pkg::rsp_type t;
         b = r.text_byte;
         step_q.delete();
         if (r.end_of_text) begin
            case (mode)
               SCAN_SPACE: emit(css_tc_pkg::KIND_SPACE, run_len);
               SCAN_IDENT, SCAN_ATKW, SCAN_CLASS: emit(name_kind(), run_len);
               SCAN_STAR: emit(css_tc_pkg::KIND_STAR, 1);
               SCAN_HASH: emit((run_len > 1) ? css_tc_pkg::KIND_HASH :
                               css_tc_pkg::KIND_UNKNOWN, run_len);
               SCAN_AT, SCAN_DOT, SCAN_SLASH: emit(css_tc_pkg::KIND_UNKNOWN, 1);
               SCAN_COMMENT: emit(css_tc_pkg::KIND_UNKNOWN, run_len);
               default: ;
            endcase
            clear_token();
         end else begin
            case (mode)
               SCAN_SPACE: begin
                  if (is_blank(b)) begin
                     run_len = bump(run_len);
                     cr_seen = (b == CH_CR);
                  end else begin
                     emit(css_tc_pkg::KIND_SPACE, run_len);
                     open_token(b);
                  end
               end
               SCAN_IDENT, SCAN_ATKW, SCAN_CLASS: begin
                  if (dash_count == 1 && b == CH_DASH) begin
                     dash_count = 2;
                     run_len = bump(run_len);
                  end else if (is_name_char(b)) begin
                     if (dash_count == 1)
                        dash_count = 0;
                     run_len = bump(run_len);
                  end else if (mode == SCAN_IDENT && b == CH_LPAREN) begin
                     emit(css_tc_pkg::KIND_FUNCTION, bump(run_len));
                     clear_token();
                  end else if (mode == SCAN_IDENT && b == CH_PIPE) begin
                     emit(css_tc_pkg::KIND_NSPREFIX, bump(run_len));
                     clear_token();
                  end else begin
                     emit(name_kind(), run_len);
                     open_token(b);
                  end
               end
               SCAN_STAR: begin
                  if (b == CH_PIPE) begin
                     emit(css_tc_pkg::KIND_NSPREFIX, 2);
                     clear_token();
                  end else begin
                     emit(css_tc_pkg::KIND_STAR, 1);
                     open_token(b);
                  end
               end
               SCAN_AT, SCAN_DOT: begin
                  if (is_name_start(b)) begin
                     mode = (mode == SCAN_AT) ? SCAN_ATKW : SCAN_CLASS;
                     run_len = 2;
                     dash_count = (b == CH_DASH) ? 1 : 0;
                  end else begin
                     emit(css_tc_pkg::KIND_UNKNOWN, 1);
                     open_token(b);
                  end
               end
               SCAN_HASH: begin
                  if (b == CH_DASH || is_name_char(b)) begin
                     run_len = bump(run_len);
                  end else begin
                     emit((run_len > 1) ? css_tc_pkg::KIND_HASH :
                          css_tc_pkg::KIND_UNKNOWN, run_len);
                     open_token(b);
                  end
               end
               SCAN_SLASH: begin
                  if (b == CH_STAR) begin
                     mode = SCAN_COMMENT;
                     run_len = 2;
                     star_seen = 1'b0;
                  end else begin
                     emit(css_tc_pkg::KIND_UNKNOWN, 1);
                     open_token(b);
                  end
               end
               SCAN_COMMENT: begin
                  if (star_seen && b == CH_SLASH) begin
                     emit(css_tc_pkg::KIND_COMMENT, bump(run_len));
                     clear_token();
                  end else begin
                     run_len = bump(run_len);
                     star_seen = (b == CH_STAR);
                  end
               end
               default: open_token(b);
            endcase
         end
         foreach (step_q[i]) begin
            t = step_q[i];
            t.last_of_run = (i == step_q.size() - 1);
            expected_q.push_back(t);
         end
      endfunction

      function void check_token(css_tc_pkg::rsp_type got);
         css_tc_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected token: kind %0d length %0d", got.token_kind, got.token_length);
            failures++;
            return;
         end
         want = expected_q.pop_front();
         if (got.token_kind !== want.token_kind) begin
            $error("token_kind: expected %0d, actual %0d", want.token_kind, got.token_kind);
            failures++;
         end
         if (got.token_length !== want.token_length) begin
            $error("token_length: expected %0d, actual %0d", want.token_length,
               got.token_length);
            failures++;
         end
         if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, actual %0d", want.last_of_run, got.last_of_run);
            failures++;
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   token_scoreboard sb;

   css_token_classifier dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_data(req_data),
      .req_full(req_full),
      .rsp_empty(rsp_empty),
      .rsp_data(rsp_data),
      .rsp_pop(rsp_pop)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic [7:0] pick_letter();
      int unsigned k;
      k = $urandom_range(0, 51);
      return (k < 26) ? 8'h61 + 8'(k) : 8'h41 + 8'(k - 26);
   endfunction

   function automatic logic [7:0] pick_name_char();
      int unsigned k;
      k = $urandom_range(0, 9);
      if (k == 0)
         return CH_UNDERSCORE;
      if (k < 4)
         return 8'h30 + 8'($urandom_range(0, 9));
      return pick_letter();
   endfunction

   function automatic logic [7:0] pick_space();
      case ($urandom_range(0, 4))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_LF;
         3: return CH_FF;
         default: return CH_CR;
      endcase
   endfunction

   // offer one byte until the block takes it, then maybe pause
   task automatic put_byte(input logic [7:0] b, input logic eot);
      css_tc_pkg::req_type r;
      r.text_byte = b;
      r.end_of_text = eot;
      req_push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_full);
      sb.note_byte(r);
      sent_bytes++;
      if (sender_idles && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic put_text(input string s);
      foreach (s[i])
         put_byte(s[i], 1'b0);
   endtask

   task automatic put_name();
      case ($urandom_range(0, 3))
         0: put_byte(CH_DASH, 1'b0);
         1: begin
            put_byte(CH_DASH, 1'b0);
            put_byte(CH_DASH, 1'b0);
         end
         default: ;
      endcase
      put_byte(($urandom_range(0, 4) == 0) ? CH_UNDERSCORE : pick_letter(), 1'b0);
      repeat ($urandom_range(0, 8))
         put_byte(pick_name_char(), 1'b0);
   endtask

   // mostly well-formed tokens with random content, plus lone marks, noise and end of text
   task automatic put_fragment();
      case ($urandom_range(0, 15))
         0, 1, 2: begin
            repeat ($urandom_range(1, 5)) begin
               if ($urandom_range(0, 3) == 0)
                  put_byte(CH_CR, 1'b0);
               put_byte(($urandom_range(0, 1) == 0) ? CH_LF : pick_space(), 1'b0);
            end
         end
         3, 4, 5: begin
            put_name();
            case ($urandom_range(0, 3))
               0: put_byte(CH_LPAREN, 1'b0);
               1: put_byte(CH_PIPE, 1'b0);
               default: ;
            endcase
         end
         6: begin
            put_byte(CH_AT, 1'b0);
            put_name();
         end
         7: begin
            put_byte(CH_DOT, 1'b0);
            put_name();
         end
         8: begin
            put_byte(CH_HASH, 1'b0);
            repeat ($urandom_range(0, 6))
               put_byte(($urandom_range(0, 4) == 0) ? CH_DASH : pick_name_char(), 1'b0);
         end
         9: begin
            put_byte(CH_SLASH, 1'b0);
            put_byte(CH_STAR, 1'b0);
            repeat ($urandom_range(0, 8)) begin
               case ($urandom_range(0, 3))
                  0: put_byte(CH_STAR, 1'b0);
                  1: put_byte(CH_SLASH, 1'b0);
                  2: put_byte(pick_letter(), 1'b0);
                  default: put_byte(8'($urandom_range(0, 255)), 1'b0);
               endcase
            end
            // now and then leave the comment open
            if ($urandom_range(0, 7) != 0) begin
               put_byte(CH_STAR, 1'b0);
               put_byte(CH_SLASH, 1'b0);
            end
         end
         10: begin
            put_byte(CH_STAR, 1'b0);
            if ($urandom_range(0, 1) == 0)
               put_byte(CH_PIPE, 1'b0);
         end
         11: put_byte(CH_COLON, 1'b0);
         12: begin
            case ($urandom_range(0, 3))
               0: put_byte(CH_AT, 1'b0);
               1: put_byte(CH_DOT, 1'b0);
               2: put_byte(CH_HASH, 1'b0);
               default: put_byte(CH_SLASH, 1'b0);
            endcase
         end
         13, 14: put_byte(8'($urandom_range(0, 255)), 1'b0);
         default: put_byte(8'($urandom_range(0, 255)), 1'b1);
      endcase
   endtask

   // result side: pops in random bursts, plus one long hold-off on request
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty)
            sb.check_token(rsp_data);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
            hold_left = $urandom_range(1, 10) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      sender_idles = 1'b1;
      receiver_idles = 1'b1;

      // dashed function, star prefix, at-keyword, class, hash, comment, colon, CRLF
      put_text("--x(*|@k.c#9/**/:\015\012");
      put_byte(8'hFF, 1'b0);
      put_byte(8'h00, 1'b0);
      // lone hash at end of text, then an open comment flushed as unknown
      put_byte(CH_HASH, 1'b0);
      put_byte(8'h00, 1'b1);
      put_text("/*a");
      put_byte(8'hFF, 1'b1);
      // end of text with nothing open
      put_byte(8'h00, 1'b1);

      // receiver stalls while the text keeps coming, so the queue backs up
      hold_request = 1'b1;
      sent_bytes = 0;
      while (sent_bytes < BUSY_BYTES)
         put_fragment();

      // closing stretch with no pauses on either side
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      sent_bytes = 0;
      while (sent_bytes < CALM_BYTES)
         put_fragment();
      put_byte(8'h00, 1'b1);
      req_push <= 1'b0;

      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
